// File: hdl/link_reconnect_backoff_fsm_top_macros.svh
// Assertion macros for the link reconnect backoff controller.
// No dependencies; included by the top level.
`ifndef LINK_RECONNECT_BACKOFF_FSM_TOP_MACROS_SVH
`define LINK_RECONNECT_BACKOFF_FSM_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LRB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define LRB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lrb_pkg.sv
// Package for the link reconnect backoff controller: payload structs,
// phase enum, register indexes and reset values. No dependencies.
`default_nettype none

package lrb_pkg;

  // Width of the wrapping millisecond clock used for elapsed-time math
  localparam int TIME_BITS = 32;
  typedef logic [TIME_BITS-1:0] time_t;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CONNECT_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_BASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_MULT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_MAX   = 3'd4;

  // Register reset values
  localparam logic [15:0] CONNECT_STEP_RST = 16'd500;
  localparam logic [7:0]  MAX_STEPS_RST    = 8'd20;
  localparam logic [31:0] BACKOFF_BASE_RST = 32'd1000;
  localparam logic [4:0]  BACKOFF_MULT_RST = 5'd2;
  localparam logic [31:0] BACKOFF_MAX_RST  = 32'd30000;

  // Controller phase, encoded as reported on machine_state
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_BEGIN     = 3'd1,
    PH_WAITING   = 3'd2,
    PH_CONNECTED = 3'd3,
    PH_BACKOFF   = 3'd4
  } phase_t;

  // One poll
  typedef struct packed {
    logic [31:0] now_ms;
    logic        link_up;
    logic        ssid_configured;
  } poll_t;

  // One result
  typedef struct packed {
    logic        start_connect;
    logic        drop_link;
    logic [2:0]  machine_state;
    logic [31:0] backoff_now_ms;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/link_reconnect_backoff_fsm_top.sv
// Link reconnect controller with exponential backoff, top level.
// State update and backoff multiply are combinational and feed the result register.
// Throughput: one poll per cycle; in_ready drops only while a result is stalled.
// Synchronous reset restores the register defaults, idle phase, zero stamp
// and count, and a backoff of 1000 ms.
// Depends on lrb_pkg and link_reconnect_backoff_fsm_top_macros.svh.
`default_nettype none

`include "link_reconnect_backoff_fsm_top_macros.svh"

module link_reconnect_backoff_fsm_top
  import lrb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // poll channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire poll_t                 in_data,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output result_t                    out_data,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [15:0] connect_step_ms;
  logic [7:0]  max_connect_steps;
  logic [31:0] backoff_base_ms;
  logic [4:0]  backoff_multiplier;
  logic [31:0] backoff_max_ms;

  // Controller state
  phase_t      phase, phase_next;
  time_t       step_stamp, step_stamp_next;
  logic [7:0]  attempt_steps, attempt_steps_next;
  logic [31:0] backoff_delay, backoff_delay_next;

  // Per-poll signals
  logic        in_fire;
  time_t       now_t;
  time_t       elapsed;
  logic        step_due;
  logic        backoff_due;
  logic [7:0]  steps_inc;
  logic [36:0] grow_prod;
  logic [31:0] grow_sat;
  logic [31:0] grow_val;
  logic        start_next, drop_next;
  result_t     result_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      connect_step_ms    <= CONNECT_STEP_RST;
      max_connect_steps  <= MAX_STEPS_RST;
      backoff_base_ms    <= BACKOFF_BASE_RST;
      backoff_multiplier <= BACKOFF_MULT_RST;
      backoff_max_ms     <= BACKOFF_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CONNECT_STEP: connect_step_ms    <= cfg_data[15:0];
        REG_MAX_STEPS:    max_connect_steps  <= cfg_data[7:0];
        REG_BACKOFF_BASE: backoff_base_ms    <= cfg_data;
        REG_BACKOFF_MULT: backoff_multiplier <= cfg_data[4:0];
        REG_BACKOFF_MAX:  backoff_max_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Elapsed time and step comparisons
  assign now_t       = time_t'(in_data.now_ms);
  assign elapsed     = now_t - step_stamp;
  assign step_due    = 64'(elapsed) >= 64'(connect_step_ms);
  assign backoff_due = 64'(elapsed) >= 64'(backoff_delay);
  assign steps_inc   = attempt_steps + 8'd1;

  // Backoff growth: saturate to 32 bits, then clamp to the ceiling
  assign grow_prod = 37'(backoff_delay) * 37'(backoff_multiplier);
  assign grow_sat  = (|grow_prod[36:32]) ? 32'hFFFF_FFFF : grow_prod[31:0];
  assign grow_val  = (grow_sat < backoff_max_ms) ? grow_sat : backoff_max_ms;

  // Next-state logic
  always_comb begin
    phase_next         = phase;
    step_stamp_next    = step_stamp;
    attempt_steps_next = attempt_steps;
    backoff_delay_next = backoff_delay;
    if (in_data.ssid_configured) begin
      case (phase)
        PH_IDLE: begin
          if (!in_data.link_up) begin
            step_stamp_next    = now_t;
            attempt_steps_next = 8'd0;
            phase_next         = PH_WAITING;
          end
        end
        PH_BEGIN: begin
          step_stamp_next    = now_t;
          attempt_steps_next = 8'd0;
          phase_next         = PH_WAITING;
        end
        PH_WAITING: begin
          if (in_data.link_up) begin
            backoff_delay_next = backoff_base_ms;
            phase_next         = PH_CONNECTED;
          end else if (step_due) begin
            step_stamp_next    = now_t;
            attempt_steps_next = steps_inc;
            if (steps_inc >= max_connect_steps) begin
              phase_next = PH_BACKOFF;
            end
          end
        end
        PH_CONNECTED: begin
          if (!in_data.link_up) begin
            phase_next = PH_BEGIN;
          end
        end
        PH_BACKOFF: begin
          if (backoff_due) begin
            backoff_delay_next = grow_val;
            phase_next         = PH_BEGIN;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Output pulses
  always_comb begin
    start_next = 1'b0;
    drop_next  = 1'b0;
    if (in_data.ssid_configured) begin
      case (phase)
        PH_IDLE:    start_next = !in_data.link_up;
        PH_BEGIN:   start_next = 1'b1;
        PH_WAITING: drop_next  = !in_data.link_up && step_due &&
                                 (steps_inc >= max_connect_steps);
        default: ;
      endcase
    end
  end

  always_comb begin
    result_next.start_connect  = start_next;
    result_next.drop_link      = drop_next;
    result_next.machine_state  = phase_next;
    result_next.backoff_now_ms = backoff_delay_next;
  end

  // State registers, updated once per poll transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      step_stamp    <= '0;
      attempt_steps <= 8'd0;
      backoff_delay <= BACKOFF_BASE_RST;
    end else if (in_fire) begin
      phase         <= phase_next;
      step_stamp    <= step_stamp_next;
      attempt_steps <= attempt_steps_next;
      backoff_delay <= backoff_delay_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result_next;
    end
  end

  // Checks
  `LRB_ASSERT_IMP(a_one_pulse, clk, rst, out_valid,
    !(out_data.start_connect && out_data.drop_link), "start and drop in one result")
  `LRB_ASSERT_IMP(a_drop_state, clk, rst, out_valid && out_data.drop_link,
    out_data.machine_state == PH_BACKOFF, "drop_link without entering backoff")
  `LRB_ASSERT_IMP(a_start_state, clk, rst, out_valid && out_data.start_connect,
    out_data.machine_state == PH_WAITING, "start_connect without entering waiting")
  `LRB_ASSERT_NXT(a_fire_result, clk, rst, in_fire,
    out_valid && out_data.machine_state == phase, "accepted poll left no result")

endmodule

`default_nettype wire
